>>> hdl/rhep_pkg.sv
package rhep_pkg;

  localparam int DataW    = 8;
  localparam int IdW      = 8;
  localparam int ElemLenW = 9;
  localparam int IdxW     = 8;
  localparam int ProfW    = 16;
  localparam int RemW     = 18;
  localparam int KindW    = 3;
  localparam int InTdataW  = 8;
  localparam int OutTdataW = 56;
  localparam int OutTuserW = 4;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_HDR  = 3'd1;
  localparam logic [2:0] PH_ELEM = 3'd2;
  localparam logic [2:0] PH_LEN  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_SKIP = 3'd5;

  localparam logic [KindW-1:0] KIND_DATA  = 3'd0;
  localparam logic [KindW-1:0] KIND_END   = 3'd1;
  localparam logic [KindW-1:0] KIND_ABORT = 3'd2;
  localparam logic [KindW-1:0] KIND_UNSUP = 3'd3;
  localparam logic [KindW-1:0] KIND_EMPTY = 3'd4;

  localparam logic [ProfW-1:0] PROFILE_ONE_BYTE   = 16'hBEDE;
  localparam logic [11:0]      PROFILE_TWO_BYTE   = 12'h100;
  localparam logic [3:0]       ID_ONE_BYTE_ABORT  = 4'd15;

  typedef struct packed {
    logic [KindW-1:0]    kind;
    logic [IdW-1:0]      element_id;
    logic [ElemLenW-1:0] element_length;
    logic [IdxW-1:0]     byte_index;
    logic [DataW-1:0]    payload_byte;
    logic                last_of_element;
    logic                end_of_block;
    logic [ProfW-1:0]    profile_word;
  } rhep_result_t;

endpackage

>>> hdl/rtp_header_extension_parser_unit.sv
// RTP header-extension parser (one-byte and two-byte element forms).
// Input stream: one byte of the extension block per request, in_tdata[7:0];
// in_tuser[0] marks the first profile byte of a new block. The block header
// is a 16-bit profile and a 16-bit length in words, big-endian.
// Output stream: at most one result per input byte. out_tuser carries the
// result kind and the end-of-block flag, out_tlast marks the final data byte
// of an element, out_tdata carries id, length, byte index, data and profile.
// Other header bytes, padding and skipped bodies give no result; the last header byte
// reports an empty or unsupported block, and padding or a lone id on the final byte of
// the block reports its end. A byte enters the input register when it is accepted, and
// its result is loaded into the result register once that register is free or taken.
// Throughput: one byte per cycle while the receiver takes results; the parse state is
// updated by a single step of logic between the two registers. When the receiver
// stalls, the result register holds and the input register takes one more byte; after
// that in_tready drops until the result is taken.
// Reset (synchronous, rst_n low) empties both registers and returns the
// parser to idle; bytes before the next start mark are ignored.
module rtp_header_extension_parser_unit
  import rhep_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [InTdataW-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                 in_tuser,   // [0] start_of_block
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OutTdataW-1:0] out_tdata,  // [7:0] element_id, [16:8] element_length,
                                           // [24:17] byte_index, [32:25] payload_byte,
                                           // [48:33] profile_word, [55:49] zero
  output logic [OutTuserW-1:0] out_tuser,  // [2:0] kind, [3] end_of_block
  output logic                 out_tlast   // last_of_element
);

  logic               s1_valid_r, s1_valid_nxt;
  logic [DataW-1:0]   s1_byte_r;
  logic               s1_start_r;

  logic [2:0]          phase_r, phase_nxt;
  logic [1:0]          hdr_cnt_r, hdr_cnt_nxt;
  logic [ProfW-1:0]    profile_r, profile_nxt;
  logic [15:0]         len_words_r, len_words_nxt;
  logic [RemW-1:0]     remain_r, remain_nxt;
  logic                two_byte_r, two_byte_nxt;
  logic [IdW-1:0]      cur_id_r, cur_id_nxt;
  logic [ElemLenW-1:0] elem_len_r, elem_len_nxt;
  logic [ElemLenW-1:0] data_left_r, data_left_nxt;

  logic               out_valid_r, out_valid_nxt;
  rhep_result_t       res_r;
  rhep_result_t       res;
  logic               res_valid;
  logic               proc;

  logic [2:0]          ph;
  logic [1:0]          hc;
  logic [RemW-1:0]     rem_dec;
  logic                eob;
  logic [ElemLenW-1:0] one_len;
  logic [ElemLenW-1:0] dl_dec;
  logic [ElemLenW-1:0] idx_full;
  logic                supported;

  assign proc      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || proc;

  assign rem_dec  = remain_r - RemW'(1);
  assign eob      = (rem_dec == '0);
  assign one_len  = ElemLenW'(s1_byte_r[3:0]) + ElemLenW'(1);
  assign dl_dec   = data_left_r - ElemLenW'(1);
  assign idx_full = elem_len_r - data_left_r;

  always_comb begin
    ph            = s1_start_r ? PH_HDR : phase_r;
    hc            = s1_start_r ? 2'd0 : hdr_cnt_r;
    phase_nxt     = ph;
    hdr_cnt_nxt   = hc;
    profile_nxt   = profile_r;
    len_words_nxt = len_words_r;
    remain_nxt    = remain_r;
    two_byte_nxt  = two_byte_r;
    cur_id_nxt    = cur_id_r;
    elem_len_nxt  = elem_len_r;
    data_left_nxt = data_left_r;
    supported     = 1'b0;
    res_valid     = 1'b0;
    res           = '0;

    unique case (ph)
      PH_HDR: begin
        if (hc < 2'd2) begin
          profile_nxt = {profile_r[7:0], s1_byte_r};
        end else begin
          len_words_nxt = {len_words_r[7:0], s1_byte_r};
        end
        if (hc != 2'd3) begin
          hdr_cnt_nxt = hc + 2'd1;
        end else begin
          hdr_cnt_nxt = 2'd0;
          remain_nxt  = {len_words_nxt, 2'b00};
          supported   = (profile_r == PROFILE_ONE_BYTE) ||
                        (profile_r[15:4] == PROFILE_TWO_BYTE);
          if (supported) begin
            two_byte_nxt = (profile_r != PROFILE_ONE_BYTE);
            if (remain_nxt == '0) begin
              phase_nxt        = PH_IDLE;
              res_valid        = 1'b1;
              res.kind         = KIND_END;
              res.end_of_block = 1'b1;
            end else begin
              phase_nxt = PH_ELEM;
            end
          end else begin
            phase_nxt        = (remain_nxt == '0) ? PH_IDLE : PH_SKIP;
            res_valid        = 1'b1;
            res.kind         = KIND_UNSUP;
            res.end_of_block = (remain_nxt == '0);
          end
        end
      end
      PH_ELEM: begin
        remain_nxt = rem_dec;
        if (eob) begin
          phase_nxt = PH_IDLE;
        end
        if (!two_byte_r) begin
          if (s1_byte_r[7:4] == ID_ONE_BYTE_ABORT) begin
            phase_nxt        = eob ? PH_IDLE : PH_SKIP;
            res_valid        = 1'b1;
            res.kind         = KIND_ABORT;
            res.element_id   = IdW'(s1_byte_r[7:4]);
            res.end_of_block = eob;
          end else if (s1_byte_r == '0) begin
            if (eob) begin
              res_valid        = 1'b1;
              res.kind         = KIND_END;
              res.end_of_block = 1'b1;
            end
          end else if (RemW'(one_len) > rem_dec) begin
            phase_nxt          = eob ? PH_IDLE : PH_SKIP;
            res_valid          = 1'b1;
            res.kind           = KIND_ABORT;
            res.element_id     = IdW'(s1_byte_r[7:4]);
            res.element_length = one_len;
            res.end_of_block   = eob;
          end else begin
            cur_id_nxt    = IdW'(s1_byte_r[7:4]);
            elem_len_nxt  = one_len;
            data_left_nxt = one_len;
            phase_nxt     = PH_DATA;
          end
        end else if (eob) begin
          res_valid        = 1'b1;
          res.kind         = KIND_END;
          res.end_of_block = 1'b1;
        end else begin
          cur_id_nxt = s1_byte_r;
          phase_nxt  = PH_LEN;
        end
      end
      PH_LEN: begin
        remain_nxt = rem_dec;
        if (eob) begin
          phase_nxt = PH_IDLE;
        end
        if (cur_id_r == '0 && s1_byte_r == '0) begin
          if (eob) begin
            res_valid        = 1'b1;
            res.kind         = KIND_END;
            res.end_of_block = 1'b1;
          end else begin
            phase_nxt = PH_ELEM;
          end
        end else if (RemW'(s1_byte_r) > rem_dec) begin
          phase_nxt          = eob ? PH_IDLE : PH_SKIP;
          res_valid          = 1'b1;
          res.kind           = KIND_ABORT;
          res.element_id     = cur_id_r;
          res.element_length = ElemLenW'(s1_byte_r);
          res.end_of_block   = eob;
        end else begin
          elem_len_nxt  = ElemLenW'(s1_byte_r);
          data_left_nxt = ElemLenW'(s1_byte_r);
          if (s1_byte_r == '0) begin
            if (!eob) begin
              phase_nxt = PH_ELEM;
            end
            res_valid        = 1'b1;
            res.kind         = KIND_EMPTY;
            res.element_id   = cur_id_r;
            res.end_of_block = eob;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        data_left_nxt = dl_dec;
        remain_nxt    = rem_dec;
        if (eob) begin
          phase_nxt = PH_IDLE;
        end else if (dl_dec == '0) begin
          phase_nxt = PH_ELEM;
        end
        res_valid           = 1'b1;
        res.kind            = KIND_DATA;
        res.element_id      = cur_id_r;
        res.element_length  = elem_len_r;
        res.byte_index      = idx_full[IdxW-1:0];
        res.payload_byte    = s1_byte_r;
        res.last_of_element = (dl_dec == '0);
        res.end_of_block    = eob;
      end
      PH_SKIP: begin
        remain_nxt = rem_dec;
        if (eob) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    res.profile_word = profile_nxt;
  end

  always_comb begin
    s1_valid_nxt = (in_tvalid && in_tready) || (s1_valid_r && !proc);
    if (proc) begin
      out_valid_nxt = res_valid;
    end else begin
      out_valid_nxt = out_valid_r && !out_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_IDLE;
      hdr_cnt_r   <= '0;
      profile_r   <= '0;
      len_words_r <= '0;
      remain_r    <= '0;
      two_byte_r  <= 1'b0;
      cur_id_r    <= '0;
      elem_len_r  <= '0;
      data_left_r <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (proc) begin
        phase_r     <= phase_nxt;
        hdr_cnt_r   <= hdr_cnt_nxt;
        profile_r   <= profile_nxt;
        len_words_r <= len_words_nxt;
        remain_r    <= remain_nxt;
        two_byte_r  <= two_byte_nxt;
        cur_id_r    <= cur_id_nxt;
        elem_len_r  <= elem_len_nxt;
        data_left_r <= data_left_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r  <= in_tdata[DataW-1:0];
      s1_start_r <= in_tuser;
    end
    if (proc && res_valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_r.profile_word, res_r.payload_byte, res_r.byte_index,
                       res_r.element_length, res_r.element_id};
  assign out_tuser  = {res_r.end_of_block, res_r.kind};
  assign out_tlast  = res_r.last_of_element;

endmodule

>>> hdl/rhep_checker.sv
module rhep_checker
  import rhep_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [OutTdataW-1:0] out_tdata,
  input logic [OutTuserW-1:0] out_tuser,
  input logic                 out_tlast
);

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[2:0] == KIND_DATA || out_tuser[2:0] == KIND_END ||
                    out_tuser[2:0] == KIND_ABORT || out_tuser[2:0] == KIND_UNSUP ||
                    out_tuser[2:0] == KIND_EMPTY))
    else $error("result kind out of range");

  // only data results carry index, payload and last flag
  a_non_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2:0] != KIND_DATA) |->
      (out_tdata[32:17] == '0 && !out_tlast))
    else $error("non-data result carries data fields");

  a_end_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[2:0] == KIND_END || out_tuser[2:0] == KIND_UNSUP)) |->
      out_tdata[16:0] == '0)
    else $error("block-level result carries element fields");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled result changed");

endmodule

bind rtp_header_extension_parser_unit rhep_checker u_rhep_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

>>> test/tb_rtp_header_extension_parser_unit.sv
`timescale 1ns / 100ps

module tb_rtp_header_extension_parser_unit;
  import rhep_pkg::*;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [InTdataW-1:0]  in_tdata   = '0;
  logic                 in_tuser   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OutTdataW-1:0] out_tdata;
  logic [OutTuserW-1:0] out_tuser;
  logic                 out_tlast;

  rtp_header_extension_parser_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  bit           gaps_on     = 1'b1;
  int unsigned  bytes_sent  = 0;
  int           error_count = 0;
  rhep_result_t records_due [256];
  logic [7:0]   rec_wr      = '0;
  logic [7:0]   rec_rd      = '0;
  rhep_result_t head_record;

  // parser state as the block should hold it
  logic [2:0]          m_phase     = PH_IDLE;
  logic [1:0]          m_hdr_cnt   = '0;
  logic [ProfW-1:0]    m_profile   = '0;
  logic [15:0]         m_len_words = '0;
  logic [RemW-1:0]     m_remaining = '0;
  logic                m_two_byte  = 1'b0;
  logic [IdW-1:0]      m_id        = '0;
  logic [ElemLenW-1:0] m_elem_len  = '0;
  logic [ElemLenW-1:0] m_data_left = '0;

  task automatic add_record(input logic [KindW-1:0] kind, input logic [IdW-1:0] id,
                            input logic [ElemLenW-1:0] len, input logic [IdxW-1:0] idx,
                            input logic [DataW-1:0] pay, input logic last, input logic eob);
    rhep_result_t r;
    r.kind            = kind;
    r.element_id      = id;
    r.element_length  = len;
    r.byte_index      = idx;
    r.payload_byte    = pay;
    r.last_of_element = last;
    r.end_of_block    = eob;
    r.profile_word    = m_profile;
    records_due[rec_wr] = r;
    rec_wr = rec_wr + 8'd1;
  endtask

  function automatic logic consume_body_byte();
    m_remaining = m_remaining - RemW'(1);
    if (m_remaining == '0) begin
      m_phase = PH_IDLE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic abort_block(input logic [IdW-1:0] id, input logic [ElemLenW-1:0] len,
                             input logic eob);
    m_phase = eob ? PH_IDLE : PH_SKIP;
    add_record(KIND_ABORT, id, len, '0, '0, 1'b0, eob);
  endtask

  task automatic decode_byte(input logic [DataW-1:0] b, input logic sob);
    logic                eob;
    logic                last;
    logic [ElemLenW-1:0] len;
    logic [ElemLenW-1:0] idx;
    if (sob) begin
      m_phase   = PH_HDR;
      m_hdr_cnt = '0;
    end
    case (m_phase)
      PH_HDR: begin
        if (m_hdr_cnt < 2'd2) m_profile = {m_profile[7:0], b};
        else m_len_words = {m_len_words[7:0], b};
        if (m_hdr_cnt < 2'd3) begin
          m_hdr_cnt = m_hdr_cnt + 2'd1;
        end else begin
          m_hdr_cnt   = '0;
          m_remaining = {m_len_words, 2'b00};
          if (m_profile == PROFILE_ONE_BYTE || m_profile[15:4] == PROFILE_TWO_BYTE) begin
            m_two_byte = (m_profile != PROFILE_ONE_BYTE);
            if (m_remaining == '0) begin
              m_phase = PH_IDLE;
              add_record(KIND_END, '0, '0, '0, '0, 1'b0, 1'b1);
            end else begin
              m_phase = PH_ELEM;
            end
          end else begin
            eob     = (m_remaining == '0);
            m_phase = eob ? PH_IDLE : PH_SKIP;
            add_record(KIND_UNSUP, '0, '0, '0, '0, 1'b0, eob);
          end
        end
      end
      PH_ELEM: begin
        eob = consume_body_byte();
        if (!m_two_byte) begin
          len = {5'd0, b[3:0]} + 9'd1;
          if (b[7:4] == ID_ONE_BYTE_ABORT) begin
            abort_block({4'd0, b[7:4]}, '0, eob);
          end else if (b == '0) begin
            if (eob) add_record(KIND_END, '0, '0, '0, '0, 1'b0, 1'b1);
          end else if (RemW'(len) > m_remaining) begin
            abort_block({4'd0, b[7:4]}, len, eob);
          end else begin
            m_id        = {4'd0, b[7:4]};
            m_elem_len  = len;
            m_data_left = len;
            m_phase     = PH_DATA;
          end
        end else if (eob) begin
          add_record(KIND_END, '0, '0, '0, '0, 1'b0, 1'b1);
        end else begin
          m_id    = b;
          m_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        eob = consume_body_byte();
        if (m_id == '0 && b == '0) begin
          if (eob) add_record(KIND_END, '0, '0, '0, '0, 1'b0, 1'b1);
          else m_phase = PH_ELEM;
        end else if (RemW'(b) > m_remaining) begin
          abort_block(m_id, {1'b0, b}, eob);
        end else begin
          m_elem_len  = {1'b0, b};
          m_data_left = {1'b0, b};
          if (b == '0) begin
            if (!eob) m_phase = PH_ELEM;
            add_record(KIND_EMPTY, m_id, '0, '0, '0, 1'b0, eob);
          end else begin
            m_phase = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        idx         = m_elem_len - m_data_left;
        m_data_left = m_data_left - ElemLenW'(1);
        last        = (m_data_left == '0);
        eob         = consume_body_byte();
        if (!eob && last) m_phase = PH_ELEM;
        add_record(KIND_DATA, m_id, m_elem_len, idx[IdxW-1:0], b, last, eob);
      end
      PH_SKIP: begin
        void'(consume_body_byte());
      end
      default: begin
        m_phase = PH_IDLE;
      end
    endcase
  endtask

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_error($sformatf("%s got %h expected %h", name, got, want));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (rec_wr == rec_rd) begin
        report_error($sformatf("unexpected result tdata=%h tuser=%h tlast=%b",
                               out_tdata, out_tuser, out_tlast));
      end else begin
        head_record = records_due[rec_rd];
        rec_rd      = rec_rd + 8'd1;
        check_field("kind",            16'(out_tuser[2:0]),
                    16'(head_record.kind));
        check_field("end_of_block",    16'(out_tuser[3]),
                    16'(head_record.end_of_block));
        check_field("last_of_element", 16'(out_tlast),
                    16'(head_record.last_of_element));
        check_field("element_id",      16'(out_tdata[7:0]),
                    16'(head_record.element_id));
        check_field("element_length",  16'(out_tdata[16:8]),
                    16'(head_record.element_length));
        check_field("byte_index",      16'(out_tdata[24:17]),
                    16'(head_record.byte_index));
        check_field("payload_byte",    16'(out_tdata[32:25]),
                    16'(head_record.payload_byte));
        check_field("profile_word",    out_tdata[48:33],  head_record.profile_word);
        check_field("tdata pad",       16'(out_tdata[55:49]), '0);
      end
    end
  end

  always @(posedge clk) out_tready <= !gaps_on || ($urandom_range(99) >= 11);

  task automatic send_byte(input logic [DataW-1:0] b, input logic sob);
    while (gaps_on && $urandom_range(99) < 11) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= sob;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_byte(b, sob);
    bytes_sent++;
  endtask

  task automatic send_random_bytes(input int unsigned n);
    repeat (n) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic send_header(input logic [ProfW-1:0] profile, input logic [15:0] words);
    send_byte(profile[15:8], 1'b1);
    send_byte(profile[7:0], 1'b0);
    send_byte(words[15:8], 1'b0);
    send_byte(words[7:0], 1'b0);
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (rec_wr != rec_rd) @(posedge clk);
  endtask

  task automatic send_one_byte_body(input int unsigned total);
    int unsigned rem;
    int unsigned len;
    int unsigned pick;
    int unsigned hi;
    logic [3:0]  id;
    rem = total;
    while (rem > 0) begin
      pick = $urandom_range(99);
      id   = 4'($urandom_range(14, 0));
      if (pick < 4) begin
        id = ID_ONE_BYTE_ABORT;
        send_byte({id, 4'($urandom)}, 1'b0);
        send_random_bytes(rem - 1);
        rem = 0;
      end else if (pick < 9 && rem <= 16) begin
        // header claims more data than is left
        len = $urandom_range(16, rem);
        send_byte({id | 4'd1, 4'(len - 1)}, 1'b0);
        send_random_bytes(rem - 1);
        rem = 0;
      end else if (pick < 22 || rem == 1) begin
        send_byte(8'h00, 1'b0);
        rem--;
      end else begin
        hi  = (rem - 1 < 16) ? rem - 1 : 16;
        len = $urandom_range(hi, 1);
        send_byte({id, 4'(len - 1)}, 1'b0);
        send_random_bytes(len);
        rem -= len + 1;
      end
    end
  endtask

  task automatic send_two_byte_body(input int unsigned total);
    int unsigned rem;
    int unsigned len;
    int unsigned pick;
    int unsigned hi;
    rem = total;
    while (rem > 0) begin
      pick = $urandom_range(99);
      if (rem == 1) begin
        send_byte(8'($urandom), 1'b0);
        rem = 0;
      end else if (pick < 10 || (rem == 2 && pick < 55)) begin
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        rem -= 2;
      end else if (pick < 20 || rem == 2) begin
        send_byte(8'($urandom_range(255, 1)), 1'b0);
        send_byte(8'h00, 1'b0);
        rem -= 2;
      end else if (pick < 26 && rem <= 256) begin
        len = $urandom_range(255, rem - 1);
        send_byte(8'($urandom), 1'b0);
        send_byte(8'(len), 1'b0);
        send_random_bytes(rem - 2);
        rem = 0;
      end else begin
        hi  = (rem - 2 < 20) ? rem - 2 : 20;
        len = $urandom_range(hi, 1);
        send_byte(8'($urandom), 1'b0);
        send_byte(8'(len), 1'b0);
        send_random_bytes(len);
        rem -= len + 2;
      end
    end
  endtask

  task automatic test_directed();
    send_byte(8'hFF, 1'b0);                    // idle, no start mark
    send_byte(8'hBE, 1'b1);                    // header cut by a new start mark
    send_byte(8'hDE, 1'b0);
    send_header(PROFILE_ONE_BYTE, 16'd0);      // empty block
    send_header(16'hFFFF, 16'd0);              // unsupported, no body
    send_header(PROFILE_ONE_BYTE, 16'd1);
    send_byte(8'h00, 1'b0);                    // padding
    send_byte(8'h10, 1'b0);                    // id 1, one data byte
    send_byte(8'hAB, 1'b0);
    send_byte(8'hF0, 1'b0);                    // id 15 on the final byte
    send_header({PROFILE_TWO_BYTE, 4'hF}, 16'd2);
    send_byte(8'h05, 1'b0);                    // empty element
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);                    // padding pair
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h33, 1'b0);                    // lone id in last byte
  endtask

  task automatic test_long_element();
    send_header({PROFILE_TWO_BYTE, 4'h0}, 16'd65);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_random_bytes(255);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hC3, 1'b0);
  endtask

  task automatic test_random_blocks(input int unsigned target);
    int unsigned pick;
    int unsigned words;
    logic [15:0] prof;
    while (bytes_sent < target) begin
      pick  = $urandom_range(99);
      words = ($urandom_range(9) == 0) ? $urandom_range(16, 5) : $urandom_range(4, 0);
      if (pick < 42) begin
        send_header(PROFILE_ONE_BYTE, 16'(words));
        send_one_byte_body(words * 4);
      end else if (pick < 80) begin
        prof = {PROFILE_TWO_BYTE, 4'($urandom)};
        send_header(prof, 16'(words));
        send_two_byte_body(words * 4);
      end else if (pick < 87) begin
        case ($urandom_range(3))
          0:       prof = 16'hBEDF;
          1:       prof = 16'h1010;
          default: prof = 16'($urandom);
        endcase
        if (prof == PROFILE_ONE_BYTE || prof[15:4] == PROFILE_TWO_BYTE) prof = ~prof;
        send_header(prof, 16'(words));
        send_random_bytes(words * 4);
      end else if (pick < 94) begin
        // truncated block, cut off by the next start mark
        send_byte(8'($urandom), 1'b1);
        send_random_bytes($urandom_range(6, 0));
      end else begin
        send_random_bytes($urandom_range(3, 1));
      end
    end
  endtask

  task automatic test_back_to_back(input int unsigned count);
    gaps_on = 1'b0;
    test_random_blocks(bytes_sent + count);
    wait_results_drained();
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    wait_results_drained();
    test_long_element();
    test_random_blocks(bytes_sent + 120);
    wait_results_drained();
    test_back_to_back(120);
    test_random_blocks(650);
    wait_results_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
